/* design/rlp_enc_pkg.sv */
// Shared types and constants for the RLP item list encoder.
`timescale 1ns / 1ps

package rlp_enc_pkg;

    // Operation codes carried on the op field.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_CONT  = 2'd1;
    localparam logic [1:0] OP_LIST  = 2'd2;

    // Error codes reported with every result byte.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ORPHAN  = 2'd1;
    localparam logic [1:0] ERR_ABANDON = 2'd2;

    // RLP prefix bases and limits.
    localparam logic [7:0] RLP_STR_SHORT    = 8'h80;
    localparam logic [7:0] RLP_STR_LONG     = 8'hB7;
    localparam logic [7:0] RLP_LIST_SHORT   = 8'hC0;
    localparam logic [7:0] RLP_LIST_LONG    = 8'hF7;
    localparam logic [7:0] RLP_SHORT_MAX    = 8'd55;
    localparam logic [7:0] RLP_SINGLE_LIMIT = 8'h80;

    // Largest number of result bytes that one item can produce.
    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = 3;

    // One decoded item: its result bytes (byte 0 goes out first), how many
    // of them are valid, and the error code they all carry.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            cnt;
        logic [1:0]                  err;
    } entry_t;

endpackage

/* design/rlp_enc_build.sv */
// Combinational builder that turns one transaction into its encoded result bytes.
`timescale 1ns / 1ps

module rlp_enc_build #(
    parameter int LEN_WIDTH = 32
) (
    input  logic [1:0]            op,
    input  logic [7:0]            data_byte,
    input  logic [31:0]           length,
    input  logic [LEN_WIDTH-1:0]  remaining,
    output logic                  load,
    output rlp_enc_pkg::entry_t   entry,
    output logic [LEN_WIDTH-1:0]  remaining_next
);
    import rlp_enc_pkg::*;

    logic [LEN_WIDTH-1:0] len_w;
    logic [31:0]          len32;
    logic [2:0]           nlen;
    logic [4:0][7:0]      len_bytes;
    logic                 is_short;
    logic                 str_open;

    // Only the low LEN_WIDTH bits of the length take part.
    assign len_w    = length[LEN_WIDTH-1:0];
    assign len32    = 32'(len_w);
    assign is_short = (len32 <= 32'(RLP_SHORT_MAX));
    assign str_open = (remaining != '0);

    // Minimal count of big-endian length bytes, at least one.
    always_comb
    begin
        if (len32[31:24] != 8'd0)
        begin
            nlen = 3'd4;
        end
        else if (len32[23:16] != 8'd0)
        begin
            nlen = 3'd3;
        end
        else if (len32[15:8] != 8'd0)
        begin
            nlen = 3'd2;
        end
        else
        begin
            nlen = 3'd1;
        end
    end

    // Length bytes of a long header, most significant first, after the prefix slot.
    always_comb
    begin
        len_bytes = '0;
        case (nlen)
            3'd1:
            begin
                len_bytes[1] = len32[7:0];
            end
            3'd2:
            begin
                len_bytes[1] = len32[15:8];
                len_bytes[2] = len32[7:0];
            end
            3'd3:
            begin
                len_bytes[1] = len32[23:16];
                len_bytes[2] = len32[15:8];
                len_bytes[3] = len32[7:0];
            end
            default:
            begin
                len_bytes[1] = len32[31:24];
                len_bytes[2] = len32[23:16];
                len_bytes[3] = len32[15:8];
                len_bytes[4] = len32[7:0];
            end
        endcase
    end

    // Encode the transaction according to its operation.
    always_comb
    begin
        load           = 1'b0;
        entry          = '0;
        remaining_next = remaining;
        case (op)
            OP_CONT:
            begin
                // A continuation passes its byte through, or gives a zero byte flagged
                // as an orphan when no string is open.
                load      = 1'b1;
                entry.cnt = CNT_W'(1);
                if (str_open)
                begin
                    entry.bytes[0] = data_byte;
                    entry.err      = ERR_NONE;
                    remaining_next = remaining - LEN_WIDTH'(1);
                end
                else
                begin
                    entry.bytes[0] = 8'd0;
                    entry.err      = ERR_ORPHAN;
                end
            end
            OP_LIST:
            begin
                load           = 1'b1;
                entry.err      = str_open ? ERR_ABANDON : ERR_NONE;
                remaining_next = '0;
                if (is_short)
                begin
                    entry.bytes[0] = RLP_LIST_SHORT + len32[7:0];
                    entry.cnt      = CNT_W'(1);
                end
                else
                begin
                    entry.bytes[4:0] = len_bytes;
                    entry.bytes[0]   = RLP_LIST_LONG + 8'(nlen);
                    entry.cnt        = CNT_W'(nlen + 3'd1);
                end
            end
            OP_START:
            begin
                load           = 1'b1;
                entry.err      = str_open ? ERR_ABANDON : ERR_NONE;
                remaining_next = '0;
                if ((len32 == 32'd0) || ((len32 == 32'd1) && (data_byte == 8'd0)))
                begin
                    // Empty string, and a lone zero byte, encode as the empty string.
                    entry.bytes[0] = RLP_STR_SHORT;
                    entry.cnt      = CNT_W'(1);
                end
                else if ((len32 == 32'd1) && (data_byte < RLP_SINGLE_LIMIT))
                begin
                    // A lone small byte is its own encoding.
                    entry.bytes[0] = data_byte;
                    entry.cnt      = CNT_W'(1);
                end
                else if (is_short)
                begin
                    entry.bytes[0] = RLP_STR_SHORT + len32[7:0];
                    entry.bytes[1] = data_byte;
                    entry.cnt      = CNT_W'(2);
                    remaining_next = len_w - LEN_WIDTH'(1);
                end
                else
                begin
                    entry.bytes[4:0]         = len_bytes;
                    entry.bytes[0]           = RLP_STR_LONG + 8'(nlen);
                    entry.bytes[nlen + 3'd1] = data_byte;
                    entry.cnt                = CNT_W'(nlen + 3'd2);
                    remaining_next           = len_w - LEN_WIDTH'(1);
                end
            end
            default:
            begin
                // Unused operation: no result and no change of state.
                load = 1'b0;
            end
        endcase
    end

endmodule

/* design/rlp_item_list_encoder.sv */
// Top level of the streaming RLP string and list header encoder.
//
// Each transaction is encoded combinationally into a holding register and then
// moved to an output shift register that sends one encoded byte per cycle
// while result_stall is low. A continuation byte or an orphan continuation
// gives one result, a short string start gives one or two, a long string start
// gives up to six (prefix, up to four length bytes, first payload byte) and a
// list header up to five. Single-byte transactions run at one per cycle while
// result_stall is low. An accepted transaction is registered in the holding
// register and then moved to the output register, which presents its first
// result. The holding register takes the next transaction while the output
// register still has bytes waiting. The open-string byte count is LEN_WIDTH
// bits; length bits above it are ignored.
`timescale 1ns / 1ps

module rlp_item_list_encoder #(
    parameter int LEN_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic [31:0] length,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [1:0]  error
);
    import rlp_enc_pkg::*;

    logic                        accept;
    logic                        dec_load;
    entry_t                      dec_entry;
    logic [LEN_WIDTH-1:0]        rem_reg;
    logic [LEN_WIDTH-1:0]        rem_next;
    logic                        hold_valid_reg;
    logic                        hold_valid_next;
    entry_t                      hold_entry_reg;
    logic [CNT_W-1:0]            out_cnt_reg;
    logic [CNT_W-1:0]            out_cnt_next;
    logic [MAX_RESULTS-1:0][7:0] out_bytes_reg;
    logic [1:0]                  out_err_reg;
    logic                        out_free;
    logic                        hold_move;
    logic                        out_take;

    // Encoder for the incoming transaction.
    rlp_enc_build #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_build (
        .op             (op),
        .data_byte      (data_byte),
        .length         (length),
        .remaining      (rem_reg),
        .load           (dec_load),
        .entry          (dec_entry),
        .remaining_next (rem_next)
    );

    // Handshake control between the holding and output registers.
    assign out_take   = result_valid && !result_stall;
    assign out_free   = (out_cnt_reg == '0) || ((out_cnt_reg == CNT_W'(1)) && !result_stall);
    assign hold_move  = hold_valid_reg && out_free;
    assign item_stall = hold_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    // Next state of the holding register valid flag.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept && dec_load)
        begin
            hold_valid_next = 1'b1;
        end
        else if (hold_move)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // Next byte count of the output shift register.
    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (hold_move)
        begin
            out_cnt_next = hold_entry_reg.cnt;
        end
        else if (out_take)
        begin
            out_cnt_next = out_cnt_reg - CNT_W'(1);
        end
    end

    // Control state: open-string count and occupancy of both registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                rem_reg <= rem_next;
            end
            hold_valid_reg <= hold_valid_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    // Payload of the holding register and the output shift register.
    always_ff @(posedge clk)
    begin
        if (accept && dec_load)
        begin
            hold_entry_reg <= dec_entry;
        end
        if (hold_move)
        begin
            out_bytes_reg <= hold_entry_reg.bytes;
            out_err_reg   <= hold_entry_reg.err;
        end
        else if (out_take)
        begin
            out_bytes_reg <= out_bytes_reg >> 8;
        end
    end

    // Result transaction fields.
    assign result_valid = (out_cnt_reg != '0);
    assign out_byte     = out_bytes_reg[0];
    assign last         = (out_cnt_reg == CNT_W'(1));
    assign error        = out_err_reg;

endmodule
